@@ design/skc_pkg.sv @@
`timescale 1ns / 1ps
package skc_pkg;

  // Default sizes of the tables.
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLUMNS = 16;

  // Fixed field widths.
  localparam int KEY_W     = 32;
  localparam int PROP_W    = 16;
  localparam int POS_W     = 16;
  localparam int ROW_OUT_W = 10;
  localparam int CCOUNT_W  = 5;
  localparam int COL_IN_W  = 4;
  localparam int COL_IDX_W = 8;

  localparam logic [POS_W-1:0] NO_VALUE = '1;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 5'd16;

  // Request codes.
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_BIND   = 3'd2;
  localparam logic [2:0] REQ_RECORD = 3'd3;
  localparam logic [2:0] REQ_LOOKUP = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_COL   = 3'd4;
  localparam logic [2:0] ST_LOCKED    = 3'd5;
  localparam logic [2:0] ST_POS_LARGE = 3'd6;

  // Link between neighboring column cells: lowest matching column so far.
  typedef struct packed {
    logic                 found;
    logic [COL_IDX_W-1:0] idx;
  } link_t;

endpackage

@@ design/sorted_key_row_column_index.sv @@
`timescale 1ns / 1ps
// Sorted row-key table with a rows-by-columns table of first-value positions.
// One request is worked at a time and gives one result beat. After reset,
// and for every clear request, the block sweeps the cell memory one entry per
// cycle (MAX_ROWS * MAX_COLUMNS entries, 16384 by default) before it takes the
// next request. Insert, record and lookup run a binary search over the key
// memory, each probe passing through S_SRCH and S_SRCH_CMP (at most eleven
// probes for 1024 keys); an insert then moves each larger key up one place,
// passing through S_SH and S_SH_WR per key. A record also waits for the column
// chain, counted down from acceptance, to find the lowest bound column for its
// property, then reads the cell and writes it if still empty. Binds, locked
// inserts, bad-column lookups and unknown codes go straight to the result.
// The configuration register can be written only while the block is idle.
module sorted_key_row_column_index import skc_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_req_type,
  input  logic [KEY_W-1:0]           in_key,
  input  logic [COL_IN_W-1:0]        in_column,
  input  logic signed [PROP_W-1:0]   in_property_id,
  input  logic [POS_W-1:0]           in_value_pos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [ROW_OUT_W-1:0]       out_row_index,
  output logic [POS_W-1:0]           out_first_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CCOUNT_W-1:0]        cfg_column_count
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = $clog2(MAX_ROWS + 1);
  localparam int CDEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int NCW    = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRCH, S_SRCH_CMP, S_SH, S_SH_WR, S_CHAIN, S_CELL_CHK, S_DONE
  } state_t;

  state_t              state_r;
  logic [2:0]          req_r;
  logic [KEY_W-1:0]    key_r;
  logic [COL_IN_W-1:0] col_r;
  logic [PROP_W-1:0]   prop_r;
  logic [POS_W-1:0]    pos_r;
  logic [CW-1:0]       lo_r, hi_r, mid_r, shj_r, count_r;
  logic [CW-1:0]       mid;
  logic                hit_r, locked_r, clr_resp_r;
  logic [NCW-1:0]      ccnt_r;
  logic [CAW-1:0]      sweep_r, caddr_r;
  logic [CCOUNT_W-1:0] column_count_r;
  logic [2:0]          res_status_r, out_status_r;
  logic [ROW_OUT_W-1:0] res_row_r, out_row_r;
  logic [POS_W-1:0]    res_first_r, out_first_r;
  logic                out_valid_r;
  logic                in_acc, in_col_ok, out_load;

  // Key memory ports.
  logic              kwe;
  logic [RW-1:0]     kwaddr, kraddr;
  logic [KEY_W-1:0]  kwdata, krdata;
  // Cell memory ports.
  logic              cwe;
  logic [CAW-1:0]    cwaddr, craddr;
  logic [POS_W-1:0]  cwdata, crdata;
  logic [COL_IN_W-1:0] cell_col;

  link_t chain [MAX_COLUMNS+1];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_col_ok = ({1'b0, in_column} < column_count_r) && (32'(in_column) < MAX_COLUMNS);
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_row_index   = out_row_r;
  assign out_first_value = out_first_r;

  // Column chain: each cell passes the lowest matching column to its neighbor.
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_col
    skc_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bind_we   (in_acc && (in_req_type == REQ_BIND) && in_col_ok &&
                  (32'(in_column) == i)),
      .bind_prop (in_property_id),
      .query_prop(prop_r),
      .in_use    (32'(i) < 32'(column_count_r)),
      .link_in   (chain[i]),
      .link_r    (chain[i+1])
    );
  end

  // Key memory address and write selection.
  always_comb begin
    kraddr = RW'(mid);
    kwe    = 1'b0;
    kwaddr = RW'(shj_r);
    kwdata = krdata;
    if (state_r == S_SH) begin
      kraddr = RW'(shj_r - 1'b1);
      if (shj_r == lo_r) begin
        kwe    = 1'b1;
        kwaddr = RW'(lo_r);
        kwdata = key_r;
      end
    end else if (state_r == S_SH_WR) begin
      kwe = 1'b1;
    end
  end

  // Cell memory: sweep on reset and clear, first-value write on record.
  always_comb begin
    cell_col = (req_r == REQ_RECORD) ? COL_IN_W'(chain[MAX_COLUMNS].idx) : col_r;
    craddr   = CAW'(lo_r) * CAW'(MAX_COLUMNS) + CAW'(cell_col);
    cwe      = 1'b0;
    cwaddr   = caddr_r;
    cwdata   = pos_r;
    if (state_r == S_CLR) begin
      cwe    = 1'b1;
      cwaddr = sweep_r;
      cwdata = NO_VALUE;
    end else if (state_r == S_CELL_CHK && req_r == REQ_RECORD && crdata == NO_VALUE) begin
      cwe = 1'b1;
    end
  end

  skc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ROWS)) u_keys (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(kraddr), .rdata_r(krdata)
  );

  skc_ram #(.WIDTH(POS_W), .DEPTH(CDEPTH)) u_cells (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata), .raddr(craddr), .rdata_r(crdata)
  );

  // Request sequencer with the registered result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      sweep_r        <= '0;
      clr_resp_r     <= 1'b0;
      count_r        <= '0;
      locked_r       <= 1'b0;
      column_count_r <= CCOUNT_RESET;
      out_valid_r    <= 1'b0;
      ccnt_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        column_count_r <= cfg_column_count;
      end
      if (ccnt_r != '0 && !in_acc) begin
        ccnt_r <= ccnt_r - 1'b1;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (sweep_r == CAW'(CDEPTH - 1)) begin
            sweep_r      <= '0;
            res_status_r <= ST_OK;
            res_row_r    <= '0;
            res_first_r  <= NO_VALUE;
            state_r      <= clr_resp_r ? S_DONE : S_IDLE;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r        <= in_req_type;
            key_r        <= in_key;
            col_r        <= in_column;
            prop_r       <= in_property_id;
            pos_r        <= in_value_pos;
            lo_r         <= '0;
            hi_r         <= count_r;
            hit_r        <= 1'b0;
            ccnt_r       <= NCW'(MAX_COLUMNS);
            res_row_r    <= '0;
            res_first_r  <= NO_VALUE;
            case (in_req_type)
              REQ_CLEAR: begin
                count_r      <= '0;
                locked_r     <= 1'b0;
                clr_resp_r   <= 1'b1;
                res_status_r <= ST_OK;
                state_r      <= S_CLR;
              end
              REQ_INSERT: begin
                if (locked_r) begin
                  res_status_r <= ST_LOCKED;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_SRCH;
                end
              end
              REQ_BIND: begin
                res_status_r <= in_col_ok ? ST_OK : ST_BAD_COL;
                state_r      <= S_DONE;
              end
              REQ_RECORD: begin
                locked_r     <= 1'b1;
                res_status_r <= ST_OK;
                state_r      <= S_SRCH;
              end
              REQ_LOOKUP: begin
                if (!in_col_ok) begin
                  res_status_r <= ST_BAD_COL;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_SRCH;
                end
              end
              default: begin
                res_status_r <= ST_IGNORED;
                state_r      <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid;
            state_r <= S_SRCH_CMP;
          end else begin
            case (req_r)
              REQ_INSERT: begin
                if (hit_r) begin
                  res_status_r <= ST_IGNORED;
                  res_row_r    <= ROW_OUT_W'(lo_r);
                  state_r      <= S_DONE;
                end else if (count_r == CW'(MAX_ROWS)) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_DONE;
                end else begin
                  shj_r   <= count_r;
                  state_r <= S_SH;
                end
              end
              REQ_RECORD: begin
                if (!hit_r) begin
                  res_status_r <= ST_NOT_FOUND;
                  state_r      <= S_DONE;
                end else if (pos_r == NO_VALUE) begin
                  res_status_r <= ST_POS_LARGE;
                  res_row_r    <= ROW_OUT_W'(lo_r);
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_CHAIN;
                end
              end
              default: begin
                if (!hit_r) begin
                  res_status_r <= ST_NOT_FOUND;
                  state_r      <= S_DONE;
                end else begin
                  caddr_r <= craddr;
                  state_r <= S_CELL_CHK;
                end
              end
            endcase
          end
        end
        S_SRCH_CMP: begin
          if (krdata < key_r) begin
            lo_r <= mid_r + 1'b1;
          end else begin
            hi_r <= mid_r;
          end
          if (krdata == key_r) begin
            hit_r <= 1'b1;
          end
          state_r <= S_SRCH;
        end
        S_SH: begin
          if (shj_r == lo_r) begin
            count_r      <= count_r + 1'b1;
            res_row_r    <= ROW_OUT_W'(lo_r);
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          shj_r   <= shj_r - 1'b1;
          state_r <= S_SH;
        end
        S_CHAIN: begin
          if (ccnt_r == '0) begin
            res_row_r <= ROW_OUT_W'(lo_r);
            if (!chain[MAX_COLUMNS].found) begin
              res_status_r <= ST_IGNORED;
              state_r      <= S_DONE;
            end else begin
              caddr_r <= craddr;
              state_r <= S_CELL_CHK;
            end
          end
        end
        S_CELL_CHK: begin
          res_row_r <= ROW_OUT_W'(lo_r);
          if (req_r == REQ_RECORD) begin
            res_status_r <= (crdata == NO_VALUE) ? ST_OK : ST_IGNORED;
          end else begin
            res_first_r <= crdata;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_row_r    <= res_row_r;
            out_first_r  <= res_first_r;
            clr_resp_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ROWS))
    else $error("key count exceeds the row capacity");

  a_locked_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == REQ_INSERT && locked_r) |=>
      (state_r == S_DONE && res_status_r == ST_LOCKED))
    else $error("insert while locked was not refused");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_ready && cwe))
    else $error("cell sweep must write and hold off requests");

  a_record_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == REQ_RECORD) |=> locked_r)
    else $error("record did not lock the key table");
`endif

endmodule

@@ design/skc_ram.sv @@
`timescale 1ns / 1ps
module skc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ design/skc_cell.sv @@
`timescale 1ns / 1ps
module skc_cell import skc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     bind_we,
  input  logic [PROP_W-1:0]        bind_prop,
  input  logic [PROP_W-1:0]        query_prop,
  input  logic                     in_use,
  input  link_t                    link_in,
  output link_t                    link_r
);

  logic [PROP_W-1:0] prop_r;
  logic              bound_r;
  logic              match;
  link_t             link_nxt;

  // A lower column that already matched wins; otherwise this one may.
  assign match = bound_r && in_use && (prop_r == query_prop);

  always_comb begin
    link_nxt = link_in;
    if (!link_in.found && match) begin
      link_nxt.found = 1'b1;
      link_nxt.idx   = COL_IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= 1'b0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (bind_we) begin
        bound_r <= 1'b1;
      end
    end
  end

  // The bound property needs no reset; the bound bit guards it.
  always_ff @(posedge clk) begin
    if (bind_we) begin
      prop_r <= bind_prop;
    end
  end

endmodule

@@ verif/tb_sorted_key_row_column_index.sv @@
`timescale 1ns / 1ps
module tb_sorted_key_row_column_index;
  import skc_pkg::*;

  localparam int ROWS = DEF_MAX_ROWS;
  localparam int COLS = DEF_MAX_COLUMNS;

  typedef struct {
    logic [2:0]           status;
    logic [ROW_OUT_W-1:0] row;
    logic [POS_W-1:0]     first;
  } lookup_result_t;

  typedef struct {
    logic [2:0]         req;
    logic [KEY_W-1:0]   key;
    logic [COL_IN_W-1:0] col;
    logic [PROP_W-1:0]  prop;
    logic [POS_W-1:0]   pos;
    bit                 typed;
    lookup_result_t     res;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [2:0] in_req_type;
  logic [KEY_W-1:0] in_key;
  logic [COL_IN_W-1:0] in_column;
  logic signed [PROP_W-1:0] in_property_id;
  logic [POS_W-1:0] in_value_pos;
  logic out_valid, out_ready;
  logic [2:0] out_status;
  logic [ROW_OUT_W-1:0] out_row_index;
  logic [POS_W-1:0] out_first_value;
  logic cfg_valid, cfg_ready;
  logic [CCOUNT_W-1:0] cfg_column_count;

  // Shadow state of the block.
  logic [KEY_W-1:0]  shadow_keys [ROWS];
  int                shadow_key_count;
  logic [POS_W-1:0]  shadow_cells [ROWS*COLS];
  logic [PROP_W-1:0] shadow_col_prop [COLS];
  bit                shadow_col_bound [COLS];
  bit                shadow_locked;
  int                shadow_ccount;

  lookup_result_t pending_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;

  logic [KEY_W-1:0]  key_pool [40];
  logic [PROP_W-1:0] prop_pool [6];

  sorted_key_row_column_index dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_sorted_key_row_column_index: errors");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_row_index !== want.row) report_mismatch("row_index", out_row_index, want.row);
        if (out_first_value !== want.first)
          report_mismatch("first_value", out_first_value, want.first);
      end
    end
  end

  // Lower bound search over the shadow keys.
  function automatic int search_row(logic [KEY_W-1:0] k, output bit hit);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_key_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < shadow_key_count) && (shadow_keys[lo] == k);
    return lo;
  endfunction

  // Work out the result of one request and update the shadow state.
  function automatic lookup_result_t predict_request(request_row_t rq);
    lookup_result_t res;
    int ncols, r;
    bit hit;
    ncols = (shadow_ccount > COLS) ? COLS : shadow_ccount;
    res.status = ST_IGNORED;
    res.row = '0;
    res.first = NO_VALUE;
    case (rq.req)
      REQ_CLEAR: begin
        shadow_key_count = 0;
        shadow_locked = 0;
        foreach (shadow_cells[i]) shadow_cells[i] = NO_VALUE;
        res.status = ST_OK;
      end
      REQ_INSERT: begin
        if (shadow_locked) begin
          res.status = ST_LOCKED;
        end else begin
          r = search_row(rq.key, hit);
          if (hit) begin
            res.row = r[ROW_OUT_W-1:0];
          end else if (shadow_key_count >= ROWS) begin
            res.status = ST_FULL;
          end else begin
            for (int i = shadow_key_count; i > r; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[r] = rq.key;
            shadow_key_count++;
            res.status = ST_OK;
            res.row = r[ROW_OUT_W-1:0];
          end
        end
      end
      REQ_BIND: begin
        if (rq.col >= ncols) begin
          res.status = ST_BAD_COL;
        end else begin
          shadow_col_prop[rq.col] = rq.prop;
          shadow_col_bound[rq.col] = 1;
          res.status = ST_OK;
        end
      end
      REQ_RECORD: begin
        shadow_locked = 1;
        r = search_row(rq.key, hit);
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.row = r[ROW_OUT_W-1:0];
          if (rq.pos == NO_VALUE) begin
            res.status = ST_POS_LARGE;
          end else begin
            // The lowest bound column with this property takes the value if its cell is empty.
            for (int c = 0; c < ncols; c++) begin
              if (shadow_col_bound[c] && shadow_col_prop[c] == rq.prop) begin
                if (shadow_cells[r*COLS+c] == NO_VALUE) begin
                  shadow_cells[r*COLS+c] = rq.pos;
                  res.status = ST_OK;
                end
                break;
              end
            end
          end
        end
      end
      REQ_LOOKUP: begin
        if (rq.col >= ncols) begin
          res.status = ST_BAD_COL;
        end else begin
          r = search_row(rq.key, hit);
          if (!hit) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.row = r[ROW_OUT_W-1:0];
            res.first = shadow_cells[r*COLS+rq.col];
            res.status = ST_OK;
          end
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  // Offer one request beat and hold it until accepted.
  task automatic send_request(request_row_t rq);
    lookup_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq.req;
    in_key <= rq.key;
    in_column <= rq.col;
    in_property_id <= rq.prop;
    in_value_pos <= rq.pos;
    do @(posedge clk); while (!in_ready);
    res = predict_request(rq);
    pending_results.push_back(rq.typed ? rq.res : res);
  endtask

  task automatic send_fields(logic [2:0] req, logic [KEY_W-1:0] key,
                             logic [COL_IN_W-1:0] col, logic [PROP_W-1:0] prop,
                             logic [POS_W-1:0] pos);
    request_row_t rq;
    rq.req = req;
    rq.key = key;
    rq.col = col;
    rq.prop = prop;
    rq.pos = pos;
    rq.typed = 0;
    send_request(rq);
  endtask

  // Pause the sender until every result has come and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_column_count(int value);
    cfg_valid <= 1'b1;
    cfg_column_count <= value[CCOUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_ccount = value;
  endtask

  function automatic logic [POS_W-1:0] random_pos();
    return ($urandom_range(15) == 0) ? NO_VALUE : POS_W'($urandom);
  endfunction

  // One round: clear, load keys, some binds, then a mix of records, lookups, binds, inserts and unknown codes.
  task automatic run_round(int n_ops);
    int n_keys, pick;
    logic [KEY_W-1:0] k;
    send_fields(REQ_CLEAR, $urandom, COL_IN_W'($urandom), PROP_W'($urandom),
                POS_W'($urandom));
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    foreach (prop_pool[i]) prop_pool[i] = PROP_W'($urandom);
    n_keys = $urandom_range(4, 30);
    for (int i = 0; i < n_keys; i++)
      send_fields(REQ_INSERT, key_pool[$urandom_range(39)], COL_IN_W'($urandom),
                  PROP_W'($urandom), POS_W'($urandom));
    for (int i = 0; i < $urandom_range(2, 6); i++)
      send_fields(REQ_BIND, $urandom, COL_IN_W'($urandom), prop_pool[$urandom_range(5)],
                  POS_W'($urandom));
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(39)];
      if (pick < 45)
        send_fields(REQ_RECORD, k, COL_IN_W'($urandom),
                    ($urandom_range(7) == 0) ? PROP_W'($urandom) : prop_pool[$urandom_range(5)],
                    random_pos());
      else if (pick < 80)
        send_fields(REQ_LOOKUP, k, COL_IN_W'($urandom), PROP_W'($urandom),
                    POS_W'($urandom));
      else if (pick < 88)
        send_fields(REQ_BIND, $urandom, COL_IN_W'($urandom), prop_pool[$urandom_range(5)],
                    POS_W'($urandom));
      else if (pick < 93)
        send_fields(REQ_INSERT, k, COL_IN_W'($urandom), PROP_W'($urandom),
                    POS_W'($urandom));
      else
        send_fields(3'($urandom_range(5, 7)), $urandom, COL_IN_W'($urandom),
                    PROP_W'($urandom), POS_W'($urandom));
    end
  endtask

  // Fill the key table to capacity in ascending order, then overflow it.
  task automatic run_fill();
    send_fields(REQ_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i <= ROWS; i++)
      send_fields(REQ_INSERT, KEY_W'((i << 22) | $urandom_range(22'h3fffff)),
                  COL_IN_W'($urandom), PROP_W'($urandom), POS_W'($urandom));
    send_fields(REQ_INSERT, '0, '0, '0, '0);
    send_fields(REQ_BIND, '0, '0, 16'h0055, '0);
    for (int i = 0; i < 40; i++) begin
      send_fields(REQ_RECORD, shadow_keys[$urandom_range(ROWS-1)], '0, 16'h0055, random_pos());
      send_fields(REQ_LOOKUP, shadow_keys[$urandom_range(ROWS-1)], COL_IN_W'($urandom),
                  '0, '0);
    end
  endtask

  // Directed requests; typed results only where they are obvious.
  request_row_t directed [] = '{
    '{REQ_LOOKUP, 32'd5, 4'd0, 16'h0000, 16'h0000, 1, '{ST_NOT_FOUND, 10'd0, NO_VALUE}},
    '{REQ_BIND,   32'd0, 4'd0, 16'h8000, 16'h0000, 1, '{ST_OK, 10'd0, NO_VALUE}},
    '{REQ_BIND,   32'd0, 4'd15, 16'h7fff, 16'h0000, 1, '{ST_OK, 10'd0, NO_VALUE}},
    '{REQ_BIND,   32'd0, 4'd1, 16'h8000, 16'h0000, 1, '{ST_OK, 10'd0, NO_VALUE}},
    '{REQ_INSERT, 32'd0, 4'd0, 16'h0000, 16'h0000, 1, '{ST_OK, 10'd0, NO_VALUE}},
    '{REQ_INSERT, 32'hffffffff, 4'd0, 16'h0000, 16'h0000, 1, '{ST_OK, 10'd1, NO_VALUE}},
    '{REQ_INSERT, 32'd0, 4'd0, 16'h0000, 16'h0000, 1, '{ST_IGNORED, 10'd0, NO_VALUE}},
    '{REQ_INSERT, 32'd1000, 4'd0, 16'h0000, 16'h0000, 0, '{0, 0, 0}},
    '{REQ_RECORD, 32'hffffffff, 4'd0, 16'h8000, 16'h0000, 0, '{0, 0, 0}},
    '{REQ_RECORD, 32'hffffffff, 4'd0, 16'h8000, 16'h0001, 0, '{0, 0, 0}},
    '{REQ_INSERT, 32'd7, 4'd0, 16'h0000, 16'h0000, 1, '{ST_LOCKED, 10'd0, NO_VALUE}},
    '{REQ_RECORD, 32'd3, 4'd0, 16'h8000, 16'h0002, 1, '{ST_NOT_FOUND, 10'd0, NO_VALUE}},
    '{REQ_RECORD, 32'd0, 4'd0, 16'h8000, 16'hffff, 1, '{ST_POS_LARGE, 10'd0, NO_VALUE}},
    '{REQ_RECORD, 32'd0, 4'd0, 16'h1234, 16'h0003, 0, '{0, 0, 0}},
    '{REQ_RECORD, 32'd0, 4'd0, 16'h7fff, 16'hfffe, 0, '{0, 0, 0}},
    '{REQ_LOOKUP, 32'hffffffff, 4'd0, 16'h0000, 16'h0000, 0, '{0, 0, 0}},
    '{REQ_LOOKUP, 32'd0, 4'd15, 16'h0000, 16'h0000, 0, '{0, 0, 0}},
    '{REQ_LOOKUP, 32'd0, 4'd1, 16'h0000, 16'h0000, 0, '{0, 0, 0}},
    '{3'd5, 32'd0, 4'd0, 16'h0000, 16'h0000, 1, '{ST_IGNORED, 10'd0, NO_VALUE}},
    '{3'd6, 32'hffffffff, 4'd15, 16'hffff, 16'hffff, 1, '{ST_IGNORED, 10'd0, NO_VALUE}},
    '{3'd7, 32'd1, 4'd1, 16'h0001, 16'h0001, 1, '{ST_IGNORED, 10'd0, NO_VALUE}},
    '{REQ_CLEAR, 32'd0, 4'd0, 16'h0000, 16'h0000, 1, '{ST_OK, 10'd0, NO_VALUE}},
    '{REQ_LOOKUP, 32'd0, 4'd0, 16'h0000, 16'h0000, 1, '{ST_NOT_FOUND, 10'd0, NO_VALUE}}
  };

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_key = '0;
    in_column = '0;
    in_property_id = '0;
    in_value_pos = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_column_count = CCOUNT_RESET;
    shadow_key_count = 0;
    shadow_locked = 0;
    shadow_ccount = CCOUNT_RESET;
    foreach (shadow_cells[i]) shadow_cells[i] = NO_VALUE;
    foreach (shadow_col_bound[i]) shadow_col_bound[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 73;
    foreach (directed[i]) send_request(directed[i]);
    drain_results();

    for (int r = 0; r < 12; r++) begin
      if (r == 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 20;
      end else if (r == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (r % 4)
        0: write_column_count(16);
        1: write_column_count(1);
        default: write_column_count($urandom_range(1, 16));
      endcase
      if (r == 9) begin
        run_fill();
      end else begin
        if (r == 6) hold_request = 1;
        run_round($urandom_range(15, 25));
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_sorted_key_row_column_index: clean");
    end else begin
      $display("tb_sorted_key_row_column_index: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/skc_pkg.sv
design/skc_ram.sv
design/skc_cell.sv
design/sorted_key_row_column_index.sv
verif/tb_sorted_key_row_column_index.sv
